// ===== sv/ssp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ssp_pkg;
  typedef struct packed {
    logic [8:0] sprite_width;
    logic [8:0] sprite_height;
    logic       last_sprite;
  } in_beat_t;
  typedef struct packed {
    logic [5:0]  sprite_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] sheet_width;
    logic [15:0] sheet_height;
    logic        last_result;
  } out_beat_t;
  typedef enum logic [2:0] {S_LOAD, S_CUT, S_WALK, S_EVAL, S_PLACE, S_EMIT} state_t;
  typedef struct packed {
    logic        valid;
    logic        cut;
    logic [15:0] pw;
    logic [15:0] ph;
    logic [15:0] rw;
  } tok_t;
  typedef struct packed {
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] y;
    logic [15:0] wmax;
    logic [15:0] hsum;
    logic [15:0] limit;
    logic        first;
  } acc_t;
  localparam logic [15:0] PAD_MASK = 16'hFFFC;
  localparam logic [15:0] PAD_ADD = 16'd7;
  localparam logic [15:0] MARGIN = 16'd4;
  function automatic logic [15:0] padded(input logic [8:0] s);
    padded = ({7'd0, s} + PAD_ADD) & PAD_MASK;
  endfunction
endpackage
`default_nettype wire

// ===== sv/ssp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ssp_cell
  import ssp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  load,
  input  wire logic  [17:0] load_size,
  input  wire logic  shift,
  input  wire logic  [17:0] size_in,
  output logic [17:0] size
);
  always_ff @(posedge clk) begin
    if (load || shift) begin
      size <= load ? load_size : size_in;
    end
  end
endmodule
`default_nettype wire

// ===== sv/ssp_layout.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ssp_layout
  import ssp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  start,
  input  wire logic  step,
  input  wire logic  is_cut,
  input  wire logic  [17:0] sz,
  input  wire logic  [8:0] next_w,
  input  wire logic  has_next,
  input  wire logic  done,
  output logic [15:0] px,
  output logic [15:0] py,
  output logic [15:0] sw,
  output logic [15:0] sh
);
  acc_t a, a_next;
  logic [15:0] pw, ph;
  logic wrap;
  always_comb begin
    pw = padded(sz[8:0]);
    ph = padded(sz[17:9]);
    a_next = a;
    wrap = 1'b0;
    px = a.rx;
    py = a.first ? MARGIN : a.y;
    if (a.first) begin
      a_next.rx = a.rx + pw;
      if (ph > a.ry) a_next.ry = ph;
    end else begin
      wrap = (a.rx + pw) > a.limit;
      if (wrap) begin
        if (a.rx + MARGIN > a.wmax) a_next.wmax = a.rx + MARGIN;
        a_next.hsum = a.hsum + a.ry;
        a_next.y = a.y + a.ry;
        px = MARGIN;
        py = a.y + a.ry;
        a_next.ry = (ph > MARGIN) ? ph : MARGIN;
        a_next.rx = MARGIN + pw;
      end else begin
        a_next.rx = a.rx + pw;
        if (ph > a.ry) a_next.ry = ph;
      end
    end
    if (is_cut) begin
      a_next.wmax = a_next.rx;
      a_next.hsum = a_next.ry;
      a_next.limit = a_next.rx + (has_next ? {7'd0, next_w} : 16'd0);
      a_next.y = MARGIN + a_next.ry;
      a_next.rx = MARGIN;
      a_next.ry = MARGIN;
      a_next.first = 1'b0;
    end
    sw = (a.rx + MARGIN > a.wmax) ? a.rx + MARGIN : a.wmax;
    sh = a.hsum + a.ry + MARGIN;
    if (done) sh = a.hsum + a.ry + MARGIN;
  end
  always_ff @(posedge clk) begin
    if (start) begin
      a <= '{rx: MARGIN, ry: MARGIN, y: MARGIN, wmax: 16'd0, hsum: 16'd0,
             limit: 16'd0, first: 1'b1};
    end else if (step) begin
      a <= a_next;
    end
  end
endmodule
`default_nettype wire

// ===== sv/shelf_sprite_packer_top.sv =====
// channel | dir | payload    | handshake
// in      | in  | in_beat_t  | in_valid / in_ready
// out     | out | out_beat_t | out_valid / out_ready
// A sprite is stored by a load into the next free cell.
// On the last sprite each cut c = 1..N is tried in turn (clear, walk, compare),
// then the best cut is walked once more to place the sprites, and a beat is sent per sprite.
// The walk rotates the first N cells past the single layout unit.
// rst clears count, state, index, cut and output valid; cell contents need no reset.
// A stalled output beat holds; no sprite is taken until the set is emitted.
`timescale 1ns / 1ps
`default_nettype none
module shelf_sprite_packer_top
  import ssp_pkg::*;
#(
  parameter int MAX_SPRITES = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);
  localparam int CW = $clog2(MAX_SPRITES + 1);
  state_t state, state_next;
  logic [CW-1:0] count, cut, idx;
  logic [17:0] size [MAX_SPRITES];
  logic shift, load, start, step, done;
  logic [15:0] px, py, sw, sh;
  logic [15:0] best_w, best_h;
  logic [16:0] best_p;
  logic [CW-1:0] best_cut;
  logic [CW-1:0] n;
  logic accept;
  logic [15:0] pxs [MAX_SPRITES];
  logic [15:0] pys [MAX_SPRITES];
  logic [MAX_SPRITES-1:0] cell_load;
  logic [CW-1:0] idx_p1;
  assign accept = in_valid && in_ready;
  assign in_ready = (state == S_LOAD);
  assign idx_p1 = idx + 1'b1;
  always_comb begin
    cell_load = '0;
    load = 1'b0;
    if (accept && count < CW'(MAX_SPRITES)) begin
      load = 1'b1;
      cell_load[count[$clog2(MAX_SPRITES > 1 ? MAX_SPRITES : 2)-1:0]] = 1'b1;
    end
  end
  genvar g;
  generate
    for (g = 0; g < MAX_SPRITES; g++) begin : g_cell
      ssp_cell u_cell (
        .clk(clk), .load(cell_load[g]),
        .load_size({in_data.sprite_height, in_data.sprite_width}),
        .shift(shift),
        .size_in((CW'(g + 1) == n) ? size[0] : size[(g + 1) % MAX_SPRITES]),
        .size(size[g]));
    end
  endgenerate
  assign shift = (state == S_WALK) || (state == S_PLACE);
  assign start = (state == S_CUT) || (state == S_EVAL);
  assign step = shift;
  assign done = (idx == n);
  ssp_layout u_lay (
    .clk(clk), .start(start), .step(step),
    .is_cut(idx_p1 == cut), .sz(size[0]), .next_w(size[MAX_SPRITES > 1 ? 1 : 0][8:0]),
    .has_next(cut < n), .done(done), .px(px), .py(py), .sw(sw), .sh(sh));
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (accept && in_data.last_sprite) state_next = S_CUT;
      S_CUT:   state_next = S_WALK;
      S_WALK:  if (idx_p1 == n) state_next = S_EVAL;
      S_EVAL:  state_next = (cut == n) ? S_PLACE : S_CUT;
      S_PLACE: if (idx_p1 == n) state_next = S_EMIT;
      S_EMIT:  if (out_valid && out_ready && idx_p1 == n) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      cut <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_LOAD: begin
          if (load) count <= count + 1'b1;
          if (accept && in_data.last_sprite) begin
            n <= load ? count + 1'b1 : count;
            cut <= CW'(1);
            best_p <= '1;
            best_cut <= CW'(1);
            idx <= '0;
          end
        end
        S_CUT:  idx <= '0;
        S_WALK: idx <= idx_p1;
        S_EVAL: begin
          if ({1'b0, sw} + {1'b0, sh} < best_p) begin
            best_p <= {1'b0, sw} + {1'b0, sh};
            best_w <= sw;
            best_h <= sh;
            best_cut <= cut;
          end
          if (cut == n) begin
            cut <= ({1'b0, sw} + {1'b0, sh} < best_p) ? cut : best_cut;
          end else begin
            cut <= cut + 1'b1;
          end
          idx <= '0;
        end
        S_PLACE: idx <= (idx_p1 == n) ? '0 : idx_p1;
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            idx <= idx_p1;
            if (idx_p1 == n) count <= '0;
          end
        end
        default: ;
      endcase
    end
  end
  logic place_go;
  assign place_go = (state == S_PLACE);
  always_ff @(posedge clk) begin
    if (place_go) begin
      pxs[idx[$clog2(MAX_SPRITES > 1 ? MAX_SPRITES : 2)-1:0]] <= px;
      pys[idx[$clog2(MAX_SPRITES > 1 ? MAX_SPRITES : 2)-1:0]] <= py;
    end
  end
  logic [15:0] rd_x, rd_y;
  always_ff @(posedge clk) begin
    rd_x <= pxs[idx[$clog2(MAX_SPRITES > 1 ? MAX_SPRITES : 2)-1:0]];
    rd_y <= pys[idx[$clog2(MAX_SPRITES > 1 ? MAX_SPRITES : 2)-1:0]];
  end
  always_comb begin
    out_data.sprite_index = 6'(idx);
    out_data.pos_x = rd_x;
    out_data.pos_y = rd_y;
    out_data.sheet_width = best_w;
    out_data.sheet_height = best_h;
    out_data.last_result = (idx_p1 == n);
  end
endmodule
`default_nettype wire

// ===== sv/ssp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ssp_checker
  import ssp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in and out overlap");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_result |=> !in_ready)
    else $error("set ended early");
  a_first: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && $past(in_ready) |-> out_data.sprite_index == 6'd0)
    else $error("first index");
endmodule
bind shelf_sprite_packer_top ssp_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ssp_pkg::*;

  localparam int SET_CAP = 64;
  localparam int STALL_LIMIT = 40000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_beat_t out_data;

  shelf_sprite_packer_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // held sprite sizes of the set being loaded
  logic [8:0] held_w[SET_CAP];
  logic [8:0] held_h[SET_CAP];
  int held_count = 0;
  logic [15:0] spot_x[SET_CAP];
  logic [15:0] spot_y[SET_CAP];
  out_beat_t placements_due[$];

  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int sets_done = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit recv_hold = 0;
  int idle_cycles = 0;

  function automatic logic [15:0] pad16(input logic [8:0] s);
    logic [15:0] t;
    t = {7'd0, s} + 16'd7;
    return t & 16'hFFFC;
  endfunction

  // shelf layout of one cut; positions land in spot_x / spot_y
  task automatic shelf_layout(input int cut, input int n, output logic [15:0] sw,
                              output logic [15:0] sh);
    int rx, ry, y, lim, wmax, hsum, i, pw, ph;
    rx = 4;
    ry = 4;
    for (i = 0; i < cut; i++) begin
      ph = pad16(held_h[i]);
      spot_x[i] = 16'(rx);
      spot_y[i] = 16'd4;
      rx += pad16(held_w[i]);
      if (ph > ry) ry = ph;
    end
    wmax = rx;
    hsum = ry;
    lim = rx + (cut < n ? held_w[cut] : 0);
    y = 4 + ry;
    rx = 4;
    ry = 4;
    for (i = cut; i < n; i++) begin
      pw = pad16(held_w[i]);
      ph = pad16(held_h[i]);
      if (rx + pw > lim) begin
        if (rx + 4 > wmax) wmax = rx + 4;
        hsum += ry;
        y += ry;
        rx = 4;
        ry = 4;
      end
      spot_x[i] = 16'(rx);
      spot_y[i] = 16'(y);
      if (ph > ry) ry = ph;
      rx += pw;
    end
    if (rx + 4 > wmax) wmax = rx + 4;
    hsum += ry;
    sw = wmax[15:0];
    sh = 16'(hsum + 4);
  endtask

  task automatic predict_sprite(input in_beat_t b);
    int c, best_c;
    logic [16:0] best_p;
    logic [15:0] sw, sh, bw, bh;
    out_beat_t r;
    if (held_count < SET_CAP) begin
      held_w[held_count] = b.sprite_width;
      held_h[held_count] = b.sprite_height;
      held_count++;
    end
    if (!b.last_sprite) return;
    best_c = 1;
    best_p = 17'h1FFFF;
    bw = 0;
    bh = 0;
    for (c = 1; c <= held_count; c++) begin
      shelf_layout(c, held_count, sw, sh);
      if ({1'b0, sw} + {1'b0, sh} < best_p) begin
        best_p = {1'b0, sw} + {1'b0, sh};
        best_c = c;
        bw = sw;
        bh = sh;
      end
    end
    shelf_layout(best_c, held_count, sw, sh);
    for (c = 0; c < held_count; c++) begin
      r.sprite_index = c[5:0];
      r.pos_x = spot_x[c];
      r.pos_y = spot_y[c];
      r.sheet_width = bw;
      r.sheet_height = bh;
      r.last_result = (c + 1 == held_count);
      placements_due = {placements_due, r};
    end
    held_count = 0;
    sets_done++;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("mismatch %s at beat %0d: got %0d, want %0d", what, beats_out, got, want);
  endtask

  task automatic send_sprite(input logic [8:0] w, input logic [8:0] h, input logic last);
    in_beat_t b;
    b.sprite_width = w;
    b.sprite_height = h;
    b.last_sprite = last;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sprite(b);
    beats_in++;
  endtask

  // receiver readiness
  always @(posedge clk) begin
    if (rst || recv_hold) out_ready <= 0;
    else out_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (placements_due.size() == 0) begin
        errors++;
        $display("unexpected beat: index %0d", out_data.sprite_index);
      end else begin
        want = placements_due.pop_front();
        if (out_data.sprite_index != want.sprite_index)
          report_mismatch("sprite_index", out_data.sprite_index, want.sprite_index);
        if (out_data.pos_x != want.pos_x) report_mismatch("pos_x", out_data.pos_x, want.pos_x);
        if (out_data.pos_y != want.pos_y) report_mismatch("pos_y", out_data.pos_y, want.pos_y);
        if (out_data.sheet_width != want.sheet_width)
          report_mismatch("sheet_width", out_data.sheet_width, want.sheet_width);
        if (out_data.sheet_height != want.sheet_height)
          report_mismatch("sheet_height", out_data.sheet_height, want.sheet_height);
        if (out_data.last_result != want.last_result)
          report_mismatch("last_result", out_data.last_result, want.last_result);
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic drain;
    in_valid <= 0;
    do @(posedge clk); while (placements_due.size() != 0);
  endtask

  task automatic send_random_set(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_sprite(9'($urandom_range(511)), 9'($urandom_range(511)), i == n - 1);
  endtask

  task automatic test_directed;
    send_sprite(0, 0, 1);
    send_sprite(511, 511, 1);
    send_sprite(0, 511, 0);
    send_sprite(511, 0, 0);
    send_sprite(1, 1, 1);
    send_sprite(100, 20, 0);
    send_sprite(100, 20, 0);
    send_sprite(100, 20, 0);
    send_sprite(511, 40, 0);
    send_sprite(3, 9, 1);
    send_sprite(10, 10, 0);
    send_sprite(10, 10, 0);
    send_sprite(10, 10, 0);
    send_sprite(10, 10, 1);
    send_sprite(170, 85, 0);
    send_sprite(341, 426, 1);
    drain();
  endtask

  task automatic test_full_store;
    int i;
    for (i = 0; i < 66; i++)
      send_sprite(9'($urandom_range(511)), 9'($urandom_range(511)), i == 65);
    drain();
  endtask

  task automatic test_random_mix;
    int p, k, sent;
    for (p = 0; p < 3; p++) begin
      send_idle = p == 0 ? 25 : (p == 1 ? 47 : 0);
      recv_idle = p == 0 ? 47 : (p == 1 ? 25 : 0);
      sent = 0;
      while (sent < 55) begin
        k = $urandom_range(99) < 85 ? $urandom_range(1, 8) : $urandom_range(9, 20);
        send_random_set(k);
        sent += k;
      end
      drain();
    end
    send_idle = 0;
    recv_idle = 0;
  endtask

  task automatic test_back_pressure;
    fork
      begin
        recv_hold = 1;
        repeat (3000) @(posedge clk);
        recv_hold = 0;
      end
      begin
        send_random_set(6);
        send_random_set(6);
        send_random_set(6);
      end
    join
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random_mix();
    test_back_pressure();
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d sprites in %0d sets, %0d placement beats checked",
             beats_in, sets_done, beats_out);
    $display("extremes, a full store, random idling and a long receiver hold-off");
    if (errors == 0 && placements_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
